// ----- design/cdll_pkg.sv -----
package cdll_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 6;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_READ_ALL   = 3'd1,
        OP_INS_FRONT  = 3'd2,
        OP_INS_END    = 3'd3,
        OP_INS_AT     = 3'd4,
        OP_DEL_FRONT  = 3'd5,
        OP_DEL_END    = 3'd6,
        OP_DEL_AT     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load_req;     // capture input request, status and walk target
        logic clear;        // empty the list, all slots free
        logic step;         // cursor <= next link data
        logic ins_single;   // new slot into empty list, links to itself
        logic ins_first;    // write new slot value and links, pop free slot
        logic ins_second;   // point neighbors at the new slot
        logic del;          // unlink cursor slot, push it on the free stack
        logic push_status;  // load output register with status result
        logic push_value;   // load output register with element at cursor
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    err;         // request status is not ok
        logic    empty;
        logic    walk_done;   // cursor index reached target
        logic    read_last;   // cursor holds the final element
        logic    out_busy;    // output register holds a result that is not taken this cycle
    } t_stat;

endpackage

// ----- design/cdll_ram.sv -----
module cdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/cdll_datapath.sv -----
module cdll_datapath
    import cdll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [42:0]         i_req,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_out_take,
    output logic                o_out_valid,
    output logic [39:0]         o_out_data,
    output logic                o_out_last
);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_opcode             r_op;
    logic [VALUE_W-1:0]  r_val;
    t_status             r_st;
    logic [CW-1:0]       r_count, r_fresh, r_stk;
    logic [SW-1:0]       r_first, r_cur, r_new, r_before;
    logic [CW-1:0]       r_idx, r_target;
    logic                r_front;
    logic                r_out_valid;
    logic [39:0]         r_out_data;
    logic                r_out_last;

    t_opcode             req_op;
    logic [POS_W-1:0]    req_pos;
    logic [POS_W:0]      pos9, cnt9;
    t_status             req_st;
    logic [CW-1:0]       req_target;
    logic                req_front;
    logic                cnt_zero, cnt_full;

    logic [VALUE_W-1:0]  val_rd;
    logic [SW-1:0]       next_rd, prev_rd, stk_rd;
    logic                val_we, next_we, prev_we, alloc;
    logic [SW-1:0]       next_wa, prev_wa, next_wd, prev_wd;
    logic [SW-1:0]       rd_addr, alloc_slot;

    assign req_op     = t_opcode'(i_req[2:0]);
    assign req_pos    = i_req[42:35];
    assign pos9       = {1'b0, req_pos};
    assign cnt9       = 9'(r_count);
    assign cnt_zero   = (r_count == '0);
    assign cnt_full   = (r_count == CW'(CAPACITY));
    assign rd_addr    = i_cmd.step ? next_rd : r_cur;
    assign alloc      = i_cmd.ins_single || i_cmd.ins_first;
    assign alloc_slot = (r_stk != '0) ? stk_rd : SW'(r_fresh);
    assign val_we     = alloc;

    // value and link stores, read at the cursor
    cdll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(alloc_slot), .i_wdata(r_val),
        .i_raddr(rd_addr), .o_rdata(val_rd));
    cdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(rd_addr), .o_rdata(next_rd));
    cdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(rd_addr), .o_rdata(prev_rd));

    // stack of freed slots; never-used slots come from r_fresh
    cdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stk (
        .i_clk(i_clk), .i_we(i_cmd.del), .i_waddr(SW'(r_stk)), .i_wdata(r_cur),
        .i_raddr(SW'(r_stk - CW'(1))), .o_rdata(stk_rd));

    // link write ports; insert splices with ins_first, then ins_second
    always_comb begin
        next_we = 1'b0; next_wa = alloc_slot; next_wd = alloc_slot;
        prev_we = 1'b0; prev_wa = alloc_slot; prev_wd = alloc_slot;
        if (i_cmd.ins_single) begin
            next_we = 1'b1; prev_we = 1'b1;
        end else if (i_cmd.ins_first) begin
            // new.next = cursor, new.prev = cursor.prev
            next_we = 1'b1; next_wd = r_cur;
            prev_we = 1'b1; prev_wd = prev_rd;
        end else if (i_cmd.ins_second) begin
            // before.next = new, cursor.prev = new
            next_we = 1'b1; next_wa = r_before; next_wd = r_new;
            prev_we = 1'b1; prev_wa = r_cur;    prev_wd = r_new;
        end else if (i_cmd.del) begin
            next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
            prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
        end
    end

    // status of the incoming request against the current list
    always_comb begin
        req_st = ST_OK;
        case (req_op)
            OP_READ_ALL: if (cnt_zero) req_st = ST_EMPTY;
            OP_INS_FRONT, OP_INS_END: if (cnt_full) req_st = ST_FULL;
            OP_INS_AT: begin
                if (req_pos == '0 || pos9 > cnt9 + 9'd1) req_st = ST_RANGE;
                else if (cnt_full)                       req_st = ST_FULL;
            end
            OP_DEL_FRONT, OP_DEL_END: if (cnt_zero) req_st = ST_EMPTY;
            OP_DEL_AT: begin
                if (cnt_zero)                         req_st = ST_EMPTY;
                else if (req_pos == '0 || pos9 > cnt9) req_st = ST_RANGE;
            end
            default: req_st = ST_OK;
        endcase
    end

    // walk target: slot found before (insert) or removed (delete)
    always_comb begin
        req_target = '0;
        req_front  = 1'b0;
        case (req_op)
            OP_INS_FRONT, OP_DEL_FRONT: req_front = 1'b1;
            OP_INS_AT: begin
                // append position walks nothing, splices before the first slot
                if (pos9 <= cnt9) req_target = CW'(pos9 - 9'd1);
                req_front = (req_pos == 8'd1);
            end
            OP_DEL_END: req_target = r_count - CW'(1);
            OP_DEL_AT: begin
                req_target = CW'(pos9 - 9'd1);
                req_front  = (req_pos == 8'd1);
            end
            default: req_target = '0;
        endcase
    end

    // list head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_first <= '0;
        end else if (i_cmd.ins_single) begin
            r_first <= alloc_slot;
            r_count <= r_count + CW'(1);
        end else if (i_cmd.ins_second) begin
            r_count <= r_count + CW'(1);
            if (r_front) r_first <= r_new;
        end else if (i_cmd.del) begin
            r_count <= r_count - CW'(1);
            if (r_count == CW'(1)) r_first <= '0;
            else if (r_front)      r_first <= next_rd;
        end
    end

    // slot allocation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fresh <= '0;
            r_stk   <= '0;
        end else if (alloc) begin
            if (r_stk != '0) r_stk <= r_stk - CW'(1);
            else             r_fresh <= r_fresh + CW'(1);
        end else if (i_cmd.del) begin
            r_stk <= r_stk + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_first) begin
            r_new    <= alloc_slot;
            r_before <= prev_rd;
        end
    end

    // request capture, cursor and walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op     <= req_op;
            r_val    <= i_req[34:3];
            r_st     <= req_st;
            r_target <= req_target;
            r_front  <= req_front;
            r_cur    <= r_first;
            r_idx    <= '0;
        end else if (i_cmd.step) begin
            r_cur <= next_rd;
            r_idx <= r_idx + CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_status || i_cmd.push_value) begin
            r_out_valid <= 1'b1;
        end else if (i_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_value) begin
            r_out_data <= {6'(r_count), val_rd, ST_OK};
            r_out_last <= o_stat.read_last;
        end else if (i_cmd.push_status) begin
            r_out_data <= {6'(r_count), 32'd0, r_st};
            r_out_last <= 1'b1;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.err       = (r_st != ST_OK);
    assign o_stat.empty     = cnt_zero;
    assign o_stat.walk_done = (r_idx == r_target);
    assign o_stat.read_last = (r_idx + CW'(1) == r_count);
    assign o_stat.out_busy  = r_out_valid && !i_out_take;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;
    assign o_out_last       = r_out_last;
endmodule

// ----- design/circular_doubly_linked_list_engine.sv -----
// Sequence: a request is loaded, then checked; clear and errors go to the status result,
// an insert into an empty list writes a single slot, a delete walks and unlinks, an
// insert walks and splices. Read all: one element a cycle while the output is free.
// Requests: the next one is taken only after the last result is loaded, so a new
// request waits for the previous one; output stalls lengthen all of these.
// i_rst_n synchronous active low: list empty, all slots free, no result held.
module circular_doubly_linked_list_engine
    import cdll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], value[34:3], position[42:35], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], read_value[33:2], element_count[39:34]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    t_cmd  cmd;
    t_stat stat;

    cdll_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_stat(stat), .o_cmd(cmd));

    cdll_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(s_axis_tdata[42:0]), .i_cmd(cmd),
        .o_stat(stat), .i_out_take(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_out_data(m_axis_tdata), .o_out_last(m_axis_tlast));
endmodule

module cdll_ctrl
    import cdll_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_INS_ONE,
        S_INS_FIRST,
        S_INS_SECOND,
        S_DEL,
        S_READ,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   is_ins;

    assign is_ins = i_stat.op inside {OP_INS_FRONT, OP_INS_END, OP_INS_AT};

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.op == OP_CLEAR) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_EMIT;
                end else if (i_stat.err) begin
                    n_state = S_EMIT;
                end else if (i_stat.op == OP_READ_ALL) begin
                    n_state = S_READ;
                end else if (is_ins && i_stat.empty) begin
                    n_state = S_INS_ONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            // one link read per step
            S_WALK: begin
                if (i_stat.walk_done) n_state = is_ins ? S_INS_FIRST : S_DEL;
                else                  o_cmd.step = 1'b1;
            end
            S_INS_ONE: begin
                o_cmd.ins_single = 1'b1;
                n_state          = S_EMIT;
            end
            S_INS_FIRST: begin
                o_cmd.ins_first = 1'b1;
                n_state         = S_INS_SECOND;
            end
            S_INS_SECOND: begin
                o_cmd.ins_second = 1'b1;
                n_state          = S_EMIT;
            end
            S_DEL: begin
                o_cmd.del = 1'b1;
                n_state   = S_EMIT;
            end
            // one element per free output slot
            S_READ: begin
                if (!i_stat.out_busy) begin
                    o_cmd.push_value = 1'b1;
                    o_cmd.step       = 1'b1;
                    if (i_stat.read_last) n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.push_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ----- sim/tb_circular_doubly_linked_list_engine.sv -----
module tb_circular_doubly_linked_list_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import cdll_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLS = 4 * CAP + 40;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] value;
        logic [7:0]  position;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic        last;
        logic [5:0]  count;
    } t_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    circular_doubly_linked_list_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // list shadow: plain ordered array, position 0 is the front
    logic [31:0] shadow_list[$];
    t_request    pending_reqs[$];
    t_response   expected_rsps[$];
    int          error_count;
    int          idle_cycles;
    bit          stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic t_response status_rsp(t_status st);
        t_response r;
        r.status     = st;
        r.read_value = '0;
        r.last       = 1'b1;
        r.count      = 6'(shadow_list.size());
        return r;
    endfunction

    // predict the results of one accepted request
    function automatic void predict_list_op(t_request q);
        t_response r;
        int n;
        n = shadow_list.size();
        case (q.op)
            OP_CLEAR: begin
                shadow_list.delete();
                expected_rsps.push_back(status_rsp(ST_OK));
            end
            OP_READ_ALL: begin
                if (n == 0) expected_rsps.push_back(status_rsp(ST_EMPTY));
                for (int i = 0; i < n; i++) begin
                    r.status     = ST_OK;
                    r.read_value = shadow_list[i];
                    r.last       = (i == n - 1);
                    r.count      = 6'(n);
                    expected_rsps.push_back(r);
                end
            end
            OP_INS_FRONT, OP_INS_END: begin
                if (n >= CAP) expected_rsps.push_back(status_rsp(ST_FULL));
                else begin
                    if (q.op == OP_INS_FRONT) shadow_list.push_front(q.value);
                    else shadow_list.push_back(q.value);
                    expected_rsps.push_back(status_rsp(ST_OK));
                end
            end
            OP_INS_AT: begin
                if (q.position < 1 || q.position > n + 1)
                    expected_rsps.push_back(status_rsp(ST_RANGE));
                else if (n >= CAP) expected_rsps.push_back(status_rsp(ST_FULL));
                else begin
                    shadow_list.insert(q.position - 1, q.value);
                    expected_rsps.push_back(status_rsp(ST_OK));
                end
            end
            OP_DEL_FRONT, OP_DEL_END: begin
                if (n == 0) expected_rsps.push_back(status_rsp(ST_EMPTY));
                else begin
                    if (q.op == OP_DEL_FRONT) void'(shadow_list.pop_front());
                    else void'(shadow_list.pop_back());
                    expected_rsps.push_back(status_rsp(ST_OK));
                end
            end
            default: begin
                if (n == 0) expected_rsps.push_back(status_rsp(ST_EMPTY));
                else if (q.position < 1 || q.position > n)
                    expected_rsps.push_back(status_rsp(ST_RANGE));
                else begin
                    shadow_list.delete(q.position - 1);
                    expected_rsps.push_back(status_rsp(ST_OK));
                end
            end
        endcase
    endfunction

    function automatic t_request mk_req(t_opcode op, logic [31:0] v, logic [7:0] p);
        t_request q;
        q.op       = op;
        q.value    = v;
        q.position = p;
        return q;
    endfunction

    // driver: one request held until accepted
    int send_gap;
    always @(posedge i_clk) begin
        t_request q;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                q = s_axis_tdata[42:0];
                predict_list_op(mk_req(t_opcode'(s_axis_tdata[2:0]),
                                       s_axis_tdata[34:3], s_axis_tdata[42:35]));
                void'(pending_reqs.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if ((s_axis_tvalid && s_axis_tready ? pending_reqs.size() > 0
                                                             : pending_reqs.size() > 0)) begin
                    q = pending_reqs[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, q.position, q.value, q.op};
                    send_gap      <= gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and response stall
    int rsp_gap;
    always @(posedge i_clk) begin
        t_response want;
        int        g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rsp_gap       <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[1:0], 0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch("status", m_axis_tdata[1:0], want.status);
                    if (m_axis_tdata[33:2] !== want.read_value)
                        report_mismatch("read_value", m_axis_tdata[33:2], want.read_value);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                    if (m_axis_tdata[39:34] !== want.count)
                        report_mismatch("element_count", m_axis_tdata[39:34], want.count);
                end
            end
            // gap after each taken result, mostly short
            if (rsp_gap > 0) begin
                m_axis_tready <= 1'b0;
                rsp_gap       <= rsp_gap - 1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                g = gap_len();
                m_axis_tready <= (g == 0);
                rsp_gap       <= (g > 0) ? g - 1 : 0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on accepted handshakes
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (pending_reqs.size() > 0 || expected_rsps.size() > 0 || !stim_done)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_opcode op;
        int      n_est;
        error_count   = 0;
        idle_cycles   = 0;
        stim_done     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list cases, extremes, fill to full, ranges
        pending_reqs.push_back(mk_req(OP_READ_ALL, 32'h0, 8'd0));
        pending_reqs.push_back(mk_req(OP_DEL_FRONT, 32'h0, 8'd0));
        pending_reqs.push_back(mk_req(OP_DEL_END, 32'h0, 8'd0));
        pending_reqs.push_back(mk_req(OP_DEL_AT, 32'h0, 8'd255));
        pending_reqs.push_back(mk_req(OP_INS_AT, 32'h1, 8'd2));
        pending_reqs.push_back(mk_req(OP_INS_AT, 32'h1, 8'd0));
        pending_reqs.push_back(mk_req(OP_INS_AT, 32'h8000_0000, 8'd1));
        pending_reqs.push_back(mk_req(OP_INS_FRONT, 32'h7fff_ffff, 8'hff));
        pending_reqs.push_back(mk_req(OP_INS_END, 32'hffff_ffff, 8'd0));
        pending_reqs.push_back(mk_req(OP_INS_AT, 32'h0, 8'd4));
        pending_reqs.push_back(mk_req(OP_DEL_AT, 32'h0, 8'd0));
        pending_reqs.push_back(mk_req(OP_DEL_AT, 32'h0, 8'd5));
        pending_reqs.push_back(mk_req(OP_READ_ALL, 32'h0, 8'd0));
        pending_reqs.push_back(mk_req(OP_DEL_AT, 32'h0, 8'd2));
        for (int i = 0; i < 31; i++)
            pending_reqs.push_back(mk_req(OP_INS_END, $urandom(), 8'd0));
        pending_reqs.push_back(mk_req(OP_INS_FRONT, 32'h5, 8'd0));
        pending_reqs.push_back(mk_req(OP_INS_AT, 32'h5, 8'd33));
        pending_reqs.push_back(mk_req(OP_INS_AT, 32'h5, 8'd34));
        pending_reqs.push_back(mk_req(OP_READ_ALL, 32'h0, 8'd0));
        pending_reqs.push_back(mk_req(OP_DEL_AT, 32'h0, 8'd32));
        pending_reqs.push_back(mk_req(OP_CLEAR, 32'hffff_ffff, 8'hff));
        pending_reqs.push_back(mk_req(OP_READ_ALL, 32'h0, 8'd0));

        // random: biased toward inserts while short, deletes while long
        n_est = 0;
        for (int k = 0; k < 330; k++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 2) op = OP_CLEAR;
            else if (r < 10) op = OP_READ_ALL;
            else if (r < 55 - n_est) op = t_opcode'($urandom_range(2, 4));
            else op = t_opcode'($urandom_range(5, 7));
            pending_reqs.push_back(mk_req(op, rand_value(),
                ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, n_est + 2))));
            if (op == OP_CLEAR) n_est = 0;
            else if (op >= OP_INS_FRONT && op <= OP_INS_AT && n_est < CAP) n_est++;
            else if (op >= OP_DEL_FRONT && n_est > 0) n_est--;
        end
        stim_done = 1'b1;

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLS) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/cdll_pkg.sv
design/cdll_ram.sv
design/cdll_datapath.sv
design/circular_doubly_linked_list_engine.sv
sim/tb_circular_doubly_linked_list_engine.sv
